// ===== hw/rtl/datq_pkg.sv =====
// datq_pkg: shared types, codes and default sizes for the deferred action timer queue
// no dependencies; imported by datq_ring, datq_cmp, deferred_action_timer_queue and the testbench
`default_nettype none

package datq_pkg;

	// clock values and delays are 32-bit wrapping tick counts
	localparam int unsigned TIME_W = 32;

	// port widths of the identifier and count fields
	localparam int unsigned ID_PORT_W = 8;
	localparam int unsigned CNT_PORT_W = 4;

	// defaults for the top level parameters
	localparam int unsigned QUEUE_DEPTH_DEF = 8;
	localparam int unsigned ID_BITS_DEF = 8;

	// function codes of an input item
	localparam logic FUNC_SCHEDULE = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EVAL = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/datq_ring.sv =====
// datq_ring: slot memory of the action ring, one write port and one registered read port
// depends on datq_pkg
`default_nettype none

module datq_ring
	import datq_pkg::*;
#(
	parameter int unsigned SLOTS = QUEUE_DEPTH_DEF + 1,
	parameter int unsigned WIDTH = ID_BITS_DEF + 2 * TIME_W + 1,
	localparam int unsigned ADDR_W = $clog2(SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/datq_cmp.sv =====
// datq_cmp: shared expiry unit, wrapped elapsed time compared against the delay
// depends on datq_pkg
`default_nettype none

module datq_cmp
	import datq_pkg::*;
(
	input  wire logic [TIME_W-1:0] now,
	input  wire logic [TIME_W-1:0] created,
	input  wire logic [TIME_W-1:0] delay,
	output logic                   expired
);

	logic [TIME_W-1:0] elapsed;

	// modulo 2^32 difference, then strict compare
	always_comb begin
		elapsed = now - created;
		expired = (elapsed > delay);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/deferred_action_timer_queue.sv =====
// deferred_action_timer_queue: top level, ring pointers, sequencer and result registers
// depends on datq_pkg, datq_ring, datq_cmp
//
// channel   ports                                                   transfer
// --------  ------------------------------------------------------  ------------------------
// item in   func callback_id delay_time use_micros now_millis       start && !busy at clk
//           now_micros
// result    accepted overflow fired fired_id pending_count          done high, one cycle
//
// A schedule item, or a poll of an empty queue, strobes its result in the cycle after
// the transfer. A poll walks the ring through the single registered read port of the
// slot memory: per examined entry, S_READ presents the address, then S_EVAL compares
// and re-appends an unexpired entry, until the first expired entry or the last one.
// arst_n clears pointers, count, sequencer and result registers; slot contents are not cleared.
// busy is high while a poll walks; the receiver cannot stall, each result shows once.
`default_nettype none

module deferred_action_timer_queue
	import datq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned ID_BITS = ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  func,
	input  wire logic [ID_PORT_W-1:0]  callback_id,
	input  wire logic [TIME_W-1:0]     delay_time,
	input  wire logic                  use_micros,
	input  wire logic [TIME_W-1:0]     now_millis,
	input  wire logic [TIME_W-1:0]     now_micros,
	output logic                       done,
	output logic                       accepted,
	output logic                       overflow,
	output logic                       fired,
	output logic [ID_PORT_W-1:0]       fired_id,
	output logic [CNT_PORT_W-1:0]      pending_count
);

	localparam int unsigned SLOTS = QUEUE_DEPTH + 1;
	localparam int unsigned PTR_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned ENTRY_W = ID_BITS + 2 * TIME_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	state_t            state_q;
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [TIME_W-1:0] ms_q;
	logic [TIME_W-1:0] us_q;

	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic               we;
	logic               xfer;
	logic               full;
	logic               expired;

	logic [ID_BITS-1:0] e_id;
	logic [TIME_W-1:0]  e_dly;
	logic [TIME_W-1:0]  e_cr;
	logic               e_clk;
	logic [TIME_W-1:0]  e_now;
	logic [TIME_W-1:0]  new_created;
	logic [PTR_W-1:0]   wr_next;
	logic [PTR_W-1:0]   rd_next;

	// handshake and queue status
	assign busy = (state_q != S_IDLE);
	assign xfer = start && !busy;
	assign full = (count_q >= CNT_FULL);
	assign pending_count = CNT_PORT_W'(count_q);

	// ring pointer increments
	assign wr_next = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
	assign rd_next = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);

	// fields of the entry under examination
	assign {e_id, e_dly, e_cr, e_clk} = rdata;
	assign e_now = e_clk ? us_q : ms_q;
	assign new_created = use_micros ? now_micros : now_millis;

	// write port: new schedule entry, or re-append of an unexpired entry
	always_comb begin
		we = 1'b0;
		wdata = rdata;
		if (state_q == S_IDLE) begin
			wdata = {ID_BITS'(callback_id), delay_time, new_created, use_micros};
			we = xfer && (func == FUNC_SCHEDULE) && !full;
		end else if (state_q == S_EVAL) begin
			we = !expired;
		end
	end

	datq_ring #(
		.SLOTS (SLOTS),
		.WIDTH (ENTRY_W)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (wr_q),
		.wdata (wdata),
		.raddr (rd_q),
		.rdata (rdata)
	);

	datq_cmp u_cmp (
		.now     (e_now),
		.created (e_cr),
		.delay   (e_dly),
		.expired (expired)
	);

	// sequencer, pointers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
			rem_q <= '0;
			done <= 1'b0;
			accepted <= 1'b0;
			overflow <= 1'b0;
			fired <= 1'b0;
			fired_id <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (xfer) begin
						accepted <= 1'b0;
						overflow <= 1'b0;
						fired <= 1'b0;
						fired_id <= '0;
						if (func == FUNC_SCHEDULE) begin
							done <= 1'b1;
							if (full) begin
								overflow <= 1'b1;
							end else begin
								accepted <= 1'b1;
								wr_q <= wr_next;
								count_q <= count_q + CNT_ONE;
							end
						end else begin
							ms_q <= now_millis;
							us_q <= now_micros;
							rem_q <= count_q;
							if (count_q == '0) begin
								done <= 1'b1;
							end else begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					rd_q <= rd_next;
					if (expired) begin
						fired <= 1'b1;
						fired_id <= ID_PORT_W'(e_id);
						count_q <= count_q - CNT_ONE;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wr_q <= wr_next;
						rem_q <= rem_q - CNT_ONE;
						if (rem_q == CNT_ONE) begin
							done <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_deferred_action_timer_queue.sv =====
// tb_deferred_action_timer_queue: self-checking testbench for the deferred action timer queue
// depends on datq_pkg and deferred_action_timer_queue; drives schedule and poll transfers,
// mirrors the action ring in a local predictor and checks every strobed result against it
`timescale 1ns / 1ps

module tb_deferred_action_timer_queue
	import datq_pkg::*;
();

	localparam int unsigned RING_SLOTS = QUEUE_DEPTH_DEF + 1;
	localparam int RANDOM_ITEMS = 1080;
	localparam int CALM_TAIL = 120;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic                  func;
		logic [ID_PORT_W-1:0]  id;
		logic [TIME_W-1:0]     delay;
		logic                  micros;
		logic [TIME_W-1:0]     ms;
		logic [TIME_W-1:0]     us;
		int                    gap;
	} action_item_t;

	typedef struct {
		logic                  accepted;
		logic                  overflow;
		logic                  fired;
		logic [ID_PORT_W-1:0]  fired_id;
		logic [CNT_PORT_W-1:0] pending;
	} action_outcome_t;

	typedef enum {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// dut connections, all known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  func = FUNC_SCHEDULE;
	logic [ID_PORT_W-1:0]  callback_id = '0;
	logic [TIME_W-1:0]     delay_time = '0;
	logic                  use_micros = 1'b0;
	logic [TIME_W-1:0]     now_millis = '0;
	logic [TIME_W-1:0]     now_micros = '0;
	logic                  done;
	logic                  accepted;
	logic                  overflow;
	logic                  fired;
	logic [ID_PORT_W-1:0]  fired_id;
	logic [CNT_PORT_W-1:0] pending_count;

	// stimulus and expectation stores
	action_item_t    item_q[$];
	action_outcome_t outcome_q[$];
	action_item_t    cur;
	bit              staged = 1'b0;
	int              gap_left = 0;
	int              fails = 0;
	int              quiet_cycles = 0;

	// mirror of the action ring
	logic [ID_PORT_W-1:0] ring_id[RING_SLOTS];
	logic [TIME_W-1:0]    ring_delay[RING_SLOTS];
	logic [TIME_W-1:0]    ring_created[RING_SLOTS];
	logic                 ring_micros[RING_SLOTS];
	int unsigned          ring_wr = 0;
	int unsigned          ring_rd = 0;

	int n_sched = 0;
	int n_refused = 0;
	int n_poll = 0;
	int n_fired = 0;

	deferred_action_timer_queue u_dut (.*);

	always #6 clk = ~clk;

	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
	endfunction

	function automatic int unsigned ring_held();
		return (ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS;
	endfunction

	function automatic void ring_append(input logic [ID_PORT_W-1:0] id,
			input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] created,
			input logic micros);
		ring_id[ring_wr] = id;
		ring_delay[ring_wr] = delay;
		ring_created[ring_wr] = created;
		ring_micros[ring_wr] = micros;
		ring_wr = ring_next(ring_wr);
	endfunction

	// advance the mirrored queue by one item and record the result it must produce
	function automatic void apply_action(input action_item_t it);
		action_outcome_t o;
		int unsigned     n;
		int unsigned     r;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] elapsed;
		o = '{default: '0};
		if (it.func == FUNC_SCHEDULE) begin
			n_sched++;
			if (ring_held() >= QUEUE_DEPTH_DEF) begin
				o.overflow = 1'b1;
				n_refused++;
			end else begin
				ring_append(it.id, it.delay, it.micros ? it.us : it.ms, it.micros);
				o.accepted = 1'b1;
			end
		end else begin
			n_poll++;
			n = ring_held();
			// rotate from the oldest entry, stop at the first expired one
			for (int i = 0; i < n; i++) begin
				r = ring_rd;
				ring_rd = ring_next(ring_rd);
				now = ring_micros[r] ? it.us : it.ms;
				elapsed = now - ring_created[r];
				if (elapsed > ring_delay[r]) begin
					o.fired = 1'b1;
					o.fired_id = ring_id[r];
					n_fired++;
					break;
				end
				ring_append(ring_id[r], ring_delay[r], ring_created[r], ring_micros[r]);
			end
		end
		o.pending = CNT_PORT_W'(ring_held());
		outcome_q.push_back(o);
	endfunction

	function automatic action_item_t mk_item(input logic f, input logic [ID_PORT_W-1:0] id,
			input logic [TIME_W-1:0] delay, input logic micros,
			input logic [TIME_W-1:0] ms, input logic [TIME_W-1:0] us);
		action_item_t it;
		it.func = f;
		it.id = id;
		it.delay = delay;
		it.micros = micros;
		it.ms = ms;
		it.us = us;
		it.gap = 0;
		return it;
	endfunction

	task automatic drive_item(input action_item_t it);
		start <= 1'b1;
		func <= it.func;
		callback_id <= it.id;
		delay_time <= it.delay;
		use_micros <= it.micros;
		now_millis <= it.ms;
		now_micros <= it.us;
		cur <= it;
	endtask

	// driver: predict on each input transfer, then present the next item or idle
	always @(posedge clk) begin : driver
		action_item_t nxt;
		if (arst_n) begin
			if (start && !busy)
				apply_action(cur);
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (staged) begin
					drive_item(cur);
					staged <= 1'b0;
				end else if (item_q.size() != 0) begin
					nxt = item_q.pop_front();
					if (nxt.gap == 0) begin
						drive_item(nxt);
					end else begin
						// hold the item back for its idle burst
						cur <= nxt;
						staged <= 1'b1;
						gap_left <= nxt.gap - 1;
						start <= 1'b0;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: each done strobe is one result transfer
	always @(posedge clk) begin : monitor
		action_outcome_t exp;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result with no item outstanding");
				fails++;
			end else begin
				exp = outcome_q.pop_front();
				if (accepted !== exp.accepted) begin
					$error("accepted: expected %0d, got %0d", exp.accepted, accepted);
					fails++;
				end
				if (overflow !== exp.overflow) begin
					$error("overflow: expected %0d, got %0d", exp.overflow, overflow);
					fails++;
				end
				if (fired !== exp.fired) begin
					$error("fired: expected %0d, got %0d", exp.fired, fired);
					fails++;
				end
				if (fired_id !== exp.fired_id) begin
					$error("fired_id: expected 0x%02h, got 0x%02h", exp.fired_id, fired_id);
					fails++;
				end
				if (pending_count !== exp.pending) begin
					$error("pending_count: expected %0d, got %0d", exp.pending, pending_count);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("tb_deferred_action_timer_queue NOT OK");
				$finish;
			end
		end
	end

	initial begin
		action_item_t      it;
		logic [TIME_W-1:0] ms_now;
		logic [TIME_W-1:0] us_now;
		mix_t              mix;
		int                mix_left;
		int                gap_span;
		bit                gappy;
		int                pick;
		bit                do_sched;

		// directed: empty poll, field extremes, full queue, boundary of the delay compare
		item_q.push_back(mk_item(FUNC_POLL, 8'h3C, 32'h1234, 1'b1, 32'h0, 32'h0));
		item_q.push_back(mk_item(FUNC_SCHEDULE, 8'hFF, 32'hFFFF_FFFE, 1'b0,
			32'hFFFF_FFFF, 32'h0));
		item_q.push_back(mk_item(FUNC_SCHEDULE, 8'h00, 32'h0, 1'b1, 32'h0, 32'hFFFF_FFFF));
		// nothing expired: full rotation
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		for (int k = 1; k <= 6; k++)
			item_q.push_back(mk_item(FUNC_SCHEDULE, ID_PORT_W'(k), 32'd5, 1'b0, 32'd100,
				32'h5555_5555));
		// queue full: refused
		item_q.push_back(mk_item(FUNC_SCHEDULE, 8'hA5, 32'd7, 1'b1, 32'd100, 32'h0));
		// elapsed equal to delay does not fire
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'd105, 32'hFFFF_FFFF));
		// microsecond entry fires across the wrap
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'd105, 32'h0));
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'd106, 32'h0));
		item_q.push_back(mk_item(FUNC_SCHEDULE, 8'h5A, 32'h8000_0000, 1'b1, 32'h0,
			32'h7FFF_FFFF));
		repeat (5)
			item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'd106, 32'hFFFF_FFFF));
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'd106, 32'h0));
		// largest elapsed time against a near-maximum delay
		item_q.push_back(mk_item(FUNC_POLL, 8'h00, 32'h0, 1'b0, 32'hFFFF_FFFE, 32'h0));

		// random: fill and drain phases on clocks that creep forward and sometimes jump
		ms_now = 32'hFFFF_FFF0;
		us_now = 32'hFFFF_0000;
		mix_left = 0;
		gap_span = 0;
		gappy = 1'b0;
		for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
			if (mix_left == 0) begin
				mix = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(8, 30);
			end
			mix_left--;
			if (gap_span == 0) begin
				gappy = $urandom_range(0, 2) != 0;
				gap_span = $urandom_range(20, 60);
			end
			gap_span--;
			if ($urandom_range(0, 19) == 0)
				ms_now = $urandom;
			else
				ms_now += $urandom_range(0, 3);
			if ($urandom_range(0, 19) == 0)
				us_now = $urandom;
			else
				us_now += $urandom_range(0, 2500);
			pick = $urandom_range(0, 99);
			case (mix)
				MIX_FILL: do_sched = pick < 75;
				MIX_DRAIN: do_sched = pick < 25;
				default: do_sched = pick < 50;
			endcase
			it.func = do_sched ? FUNC_SCHEDULE : FUNC_POLL;
			it.id = ID_PORT_W'($urandom_range(0, 255));
			it.micros = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0)
				it.delay = $urandom;
			else
				it.delay = it.micros ? $urandom_range(0, 12000) : $urandom_range(0, 12);
			it.ms = ms_now;
			it.us = us_now;
			if (idx < RANDOM_ITEMS - CALM_TAIL && gappy && $urandom_range(0, 3) == 0)
				it.gap = $urandom_range(1, 6);
			else
				it.gap = 0;
			item_q.push_back(it);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (item_q.size() != 0 || staged || start)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (outcome_q.size() != 0) begin
			$error("%0d results never arrived", outcome_q.size());
			fails++;
		end
		$display("covered %0d schedule transfers (%0d refused on a full queue)",
			n_sched, n_refused);
		$display("and %0d polls, %0d of which fired an action", n_poll, n_fired);
		if (fails == 0)
			$display("tb_deferred_action_timer_queue OK");
		else
			$display("tb_deferred_action_timer_queue NOT OK");
		$finish;
	end

endmodule
